// ===== src/days_between_dates_top_assert.svh =====
// Assertion macros used by the checker file dbd_checker.sv.
`ifndef DAYS_BETWEEN_DATES_TOP_ASSERT_SVH
`define DAYS_BETWEEN_DATES_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define DBD_CHK_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dbd_checker: property failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define DBD_CHK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dbd_checker: property failed");

`endif

// ===== src/dbd_pkg.sv =====
package dbd_pkg;

   localparam int DUE_W   = 25;
   localparam int YEAR_W  = 12;
   localparam int MON_W   = 4;
   localparam int DAY_W   = 5;
   localparam int OUT_W   = 18;

   localparam int DIV_W   = 25;
   localparam int QUO_W   = 12;
   localparam int REM_W   = 14;
   localparam int DEC_W   = 7;
   localparam int Q100_W  = 6;
   localparam int Q400_W  = 4;
   localparam int CUM_W   = 9;
   localparam int PROD_W  = 21;
   localparam int PART_W  = 12;
   localparam int ACC_W   = 23;

   localparam int YEAR_DAYS = 365;

   typedef enum logic [1:0] {
      DIV_BY_10000 = 2'd0,
      DIV_BY_100   = 2'd1,
      DIV_BY_400   = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        start;
      div_sel_type sel;
   } div_ctl_type;

   function automatic logic [REM_W-1:0] div_const(input div_sel_type sel);
      logic [REM_W-1:0] val;
      unique case (sel)
         DIV_BY_10000: val = REM_W'(10000);
         DIV_BY_100:   val = REM_W'(100);
         DIV_BY_400:   val = REM_W'(400);
         default:      val = REM_W'(100);
      endcase
      return val;
   endfunction

   // days in the months before month m of a common year
   function automatic logic [CUM_W-1:0] month_cum(input logic [DEC_W-1:0] m);
      logic [CUM_W-1:0] val;
      unique case (m)
         DEC_W'(0):  val = CUM_W'(0);
         DEC_W'(1):  val = CUM_W'(0);
         DEC_W'(2):  val = CUM_W'(31);
         DEC_W'(3):  val = CUM_W'(59);
         DEC_W'(4):  val = CUM_W'(90);
         DEC_W'(5):  val = CUM_W'(120);
         DEC_W'(6):  val = CUM_W'(151);
         DEC_W'(7):  val = CUM_W'(181);
         DEC_W'(8):  val = CUM_W'(212);
         DEC_W'(9):  val = CUM_W'(243);
         DEC_W'(10): val = CUM_W'(273);
         DEC_W'(11): val = CUM_W'(304);
         DEC_W'(12): val = CUM_W'(334);
         default:    val = CUM_W'(365);
      endcase
      return val;
   endfunction

endpackage

// ===== src/dbd_div.sv =====
module dbd_div import dbd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  div_ctl_type         ctl,
   input  logic [DIV_W-1:0]    dividend,
   output logic                done,
   output logic [QUO_W-1:0]    quotient,
   output logic [REM_W-1:0]    remainder
);

   localparam int OP_W  = DIV_W - 4;
   localparam int RCP_W = 22;
   localparam int MUL_W = OP_W + RCP_W;
   // ceil(2^31 / 625) and ceil(2^17 / 25), exact over the operand ranges below
   localparam logic [RCP_W-1:0] RCP_625 = RCP_W'(3435974);
   localparam logic [RCP_W-1:0] RCP_25  = RCP_W'(5243);
   localparam int SH_625 = 31;
   localparam int SH_25  = 17;

   logic               load_ff,   load_in;
   logic               quo_ok_ff, quo_ok_in;
   logic               done_ff,   done_in;
   div_sel_type        sel_ff,    sel_in;
   logic [DIV_W-1:0]   num_ff,    num_in;
   logic [QUO_W-1:0]   quo_ff,    quo_in;
   logic [REM_W-1:0]   rem_ff,    rem_in;
   logic [OP_W-1:0]    mul_a;
   logic [RCP_W-1:0]   mul_b;
   logic [MUL_W-1:0]   mul_p;
   logic [DIV_W-1:0]   back;

   // quotient by reciprocal multiply: dividend below 2^14 for /100, below 2^12 for /400
   always_comb begin
      unique case (sel_ff)
         DIV_BY_10000: begin
            mul_a = num_ff[DIV_W-1:4];
            mul_b = RCP_625;
         end
         DIV_BY_400: begin
            mul_a = OP_W'(num_ff[11:4]);
            mul_b = RCP_25;
         end
         default: begin
            mul_a = OP_W'(num_ff[13:2]);
            mul_b = RCP_25;
         end
      endcase
      mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
      back  = DIV_W'(quo_ff) * DIV_W'(div_const(sel_ff));

      load_in   = ctl.start;
      quo_ok_in = load_ff;
      done_in   = quo_ok_ff;
      sel_in    = sel_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (ctl.start) begin
         sel_in = ctl.sel;
         num_in = dividend;
      end
      if (load_ff) begin
         if (sel_ff == DIV_BY_10000) begin
            quo_in = mul_p[SH_625 +: QUO_W];
         end else begin
            quo_in = mul_p[SH_25 +: QUO_W];
         end
      end
      if (quo_ok_ff) begin
         rem_in = REM_W'(num_ff - back);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff   <= 1'b0;
         quo_ok_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         load_ff   <= load_in;
         quo_ok_ff <= quo_ok_in;
         done_ff   <= done_in;
      end
      sel_ff <= sel_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/days_between_dates_top.sv =====
// Channel   | Ports                                            | Handshake
// ----------+--------------------------------------------------+---------------------
// request   | req_due_date_packed, req_today_year/_month/_day  | start && !busy
// response  | rsp_overdue_days                                 | rsp_valid, one cycle
//
// Busy stays high from accept until the rsp_valid strobe and falls in the strobe cycle.
// The shared reciprocal divider runs six divisions in turn: the due year, the due
// month/day, then year/100 and year/400 for each date.
// Synchronous active-high reset returns to idle with no response pending.
// The receiver cannot stall; a new request may be taken in the strobe cycle.
module days_between_dates_top import dbd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [DUE_W-1:0]         req_due_date_packed,
   input  logic [YEAR_W-1:0]        req_today_year,
   input  logic [MON_W-1:0]         req_today_month,
   input  logic [DAY_W-1:0]         req_today_day,
   output logic                     rsp_valid,
   output logic signed [OUT_W-1:0]  rsp_overdue_days
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DIV_Y  = 9'b000000010,
      S_DIV_MD = 9'b000000100,
      S_DIV_C  = 9'b000001000,
      S_DIV_Q  = 9'b000010000,
      S_MUL    = 9'b000100000,
      S_ACC1   = 9'b001000000,
      S_ACC2   = 9'b010000000,
      S_FIN    = 9'b100000000
   } state_type;

   localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
   localparam int OUT_MIN = -(2 ** (OUT_W - 1));
   localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(OUT_MAX);
   localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(OUT_MIN);

   state_type                 state_ff, state_in;
   logic                      due_pass_ff, due_pass_in;
   logic [YEAR_W-1:0]         ty_ff, ty_in;
   logic [MON_W-1:0]          tm_ff, tm_in;
   logic [DAY_W-1:0]          td_ff, td_in;
   logic [YEAR_W-1:0]         cur_y_ff, cur_y_in;
   logic [DEC_W-1:0]          cur_m_ff, cur_m_in;
   logic [DEC_W-1:0]          cur_d_ff, cur_d_in;
   logic [Q100_W-1:0]         q100_ff, q100_in;
   logic                      nz100_ff, nz100_in;
   logic [Q400_W-1:0]         q400_ff, q400_in;
   logic                      z400_ff, z400_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [PART_W-1:0]         part_ff, part_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]   rsp_days_ff, rsp_days_in;

   div_ctl_type               div_ctl;
   logic [DIV_W-1:0]          div_dividend;
   logic                      div_done;
   logic [QUO_W-1:0]          div_quo;
   logic [REM_W-1:0]          div_rem;

   logic [YEAR_W:0]           y_plus3;
   logic                      leap;

   dbd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      due_pass_in  = due_pass_ff;
      ty_in        = ty_ff;
      tm_in        = tm_ff;
      td_in        = td_ff;
      cur_y_in     = cur_y_ff;
      cur_m_in     = cur_m_ff;
      cur_d_in     = cur_d_ff;
      q100_in      = q100_ff;
      nz100_in     = nz100_ff;
      q400_in      = q400_ff;
      z400_in      = z400_ff;
      prod_in      = prod_ff;
      part_in      = part_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_days_in  = rsp_days_ff;
      div_ctl.start = 1'b0;
      div_ctl.sel   = DIV_BY_100;
      div_dividend  = DIV_W'(cur_y_ff);
      y_plus3 = {1'b0, cur_y_ff} + (YEAR_W + 1)'(3);
      leap    = ((cur_y_ff[1:0] == 2'b00) && nz100_ff) || z400_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ty_in         = req_today_year;
               tm_in         = req_today_month;
               td_in         = req_today_day;
               acc_in        = '0;
               due_pass_in   = 1'b1;
               div_ctl.start = 1'b1;
               div_ctl.sel   = DIV_BY_10000;
               div_dividend  = req_due_date_packed;
               state_in      = S_DIV_Y;
            end
         end
         S_DIV_Y: begin
            if (div_done) begin
               cur_y_in      = div_quo;
               div_ctl.start = 1'b1;
               div_ctl.sel   = DIV_BY_100;
               div_dividend  = DIV_W'(div_rem);
               state_in      = S_DIV_MD;
            end
         end
         S_DIV_MD: begin
            if (div_done) begin
               cur_m_in      = div_quo[DEC_W-1:0];
               cur_d_in      = div_rem[DEC_W-1:0];
               div_ctl.start = 1'b1;
               div_ctl.sel   = DIV_BY_100;
               div_dividend  = DIV_W'(cur_y_ff);
               state_in      = S_DIV_C;
            end
         end
         S_DIV_C: begin
            if (div_done) begin
               q100_in       = div_quo[Q100_W-1:0];
               nz100_in      = (div_rem != '0);
               div_ctl.start = 1'b1;
               div_ctl.sel   = DIV_BY_400;
               div_dividend  = DIV_W'(cur_y_ff);
               state_in      = S_DIV_Q;
            end
         end
         S_DIV_Q: begin
            if (div_done) begin
               q400_in  = div_quo[Q400_W-1:0];
               z400_in  = (div_rem == '0);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // leap days before the year: ceil(y/4) - ceil(y/100) + ceil(y/400)
            prod_in = PROD_W'(cur_y_ff) * PROD_W'(YEAR_DAYS);
            part_in = PART_W'(y_plus3[YEAR_W:2])
                    - PART_W'(q100_ff) - PART_W'(nz100_ff)
                    + PART_W'(q400_ff) + PART_W'(!z400_ff)
                    + PART_W'(month_cum(cur_m_ff))
                    + PART_W'(leap && (cur_m_ff >= DEC_W'(3)))
                    + PART_W'(cur_d_ff);
            state_in = S_ACC1;
         end
         S_ACC1: begin
            if (due_pass_ff) begin
               acc_in = acc_ff - ACC_W'(prod_ff);
            end else begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            state_in = S_ACC2;
         end
         S_ACC2: begin
            if (due_pass_ff) begin
               acc_in        = acc_ff - ACC_W'(part_ff);
               due_pass_in   = 1'b0;
               cur_y_in      = ty_ff;
               cur_m_in      = DEC_W'(tm_ff);
               cur_d_in      = DEC_W'(td_ff);
               div_ctl.start = 1'b1;
               div_ctl.sel   = DIV_BY_100;
               div_dividend  = DIV_W'(ty_ff);
               state_in      = S_DIV_C;
            end else begin
               acc_in   = acc_ff + ACC_W'(part_ff);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            if (acc_ff > ACC_HI) begin
               rsp_days_in = OUT_W'(OUT_MAX);
            end else if (acc_ff < ACC_LO) begin
               rsp_days_in = OUT_W'(OUT_MIN);
            end else begin
               rsp_days_in = acc_ff[OUT_W-1:0];
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      due_pass_ff <= due_pass_in;
      ty_ff       <= ty_in;
      tm_ff       <= tm_in;
      td_ff       <= td_in;
      cur_y_ff    <= cur_y_in;
      cur_m_ff    <= cur_m_in;
      cur_d_ff    <= cur_d_in;
      q100_ff     <= q100_in;
      nz100_ff    <= nz100_in;
      q400_ff     <= q400_in;
      z400_ff     <= z400_in;
      prod_ff     <= prod_in;
      part_ff     <= part_in;
      acc_ff      <= acc_in;
      rsp_days_ff <= rsp_days_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_overdue_days = rsp_days_ff;

endmodule

// ===== src/dbd_checker.sv =====
`include "days_between_dates_top_assert.svh"

module dbd_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   `DBD_CHK_NEXT(a_accept_busy, start && !busy, busy)
   `DBD_CHK_NEXT(a_strobe_single, rsp_valid, !rsp_valid)
   `DBD_CHK_IMPL(a_strobe_after_busy, rsp_valid, $past(busy))
   `DBD_CHK_IMPL(a_busy_end_strobe, $fell(busy) && !$past(reset), rsp_valid)
   `DBD_CHK_IMPL(a_reset_idle, $past(reset), !busy && !rsp_valid)

endmodule

bind days_between_dates_top dbd_checker u_dbd_checker (.*);

// ===== sim/days_between_dates_top_tb.sv =====
module days_between_dates_top_tb;
   import dbd_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESULT_LATENCY = 25;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam longint OVERDUE_MAX = 131071;
   localparam longint OVERDUE_MIN = -131072;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [DUE_W-1:0]        req_due_date_packed = '0;
   logic [YEAR_W-1:0]       req_today_year = '0;
   logic [MON_W-1:0]        req_today_month = '0;
   logic [DAY_W-1:0]        req_today_day = '0;
   logic                    rsp_valid;
   logic signed [OUT_W-1:0] rsp_overdue_days;

   logic signed [OUT_W-1:0] pending_overdue[$];
   logic signed [OUT_W-1:0] oldest_overdue;
   int                      mismatch_count = 0;
   bit                      idle_enabled = 1'b1;

   days_between_dates_top dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_due_date_packed (req_due_date_packed),
      .req_today_year      (req_today_year),
      .req_today_month     (req_today_month),
      .req_today_day       (req_today_day),
      .rsp_valid           (rsp_valid),
      .rsp_overdue_days    (rsp_overdue_days)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
      $display("FAIL days_between_dates_top");
      $finish;
   end

   function automatic longint month_length(int idx);
      case (idx)
         1:       return 28;
         3, 5, 8, 10: return 30;
         default: return 31;
      endcase
   endfunction

   function automatic bit is_leap_year(longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // absolute day number counted from year 0
   function automatic longint day_index(longint y, longint m, longint d);
      longint leaps;
      longint months_before;
      longint month_sum;
      leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      months_before = (m == 0) ? 0 : ((m > 12) ? 12 : m - 1);
      month_sum = 0;
      for (int i = 0; i < months_before; i++) begin
         month_sum += month_length(i);
      end
      if (months_before >= 2 && is_leap_year(y)) begin
         month_sum += 1;
      end
      return y * 365 + leaps + month_sum + d;
   endfunction

   function automatic logic signed [OUT_W-1:0] overdue_for(logic [DUE_W-1:0] due,
         logic [YEAR_W-1:0] ty, logic [MON_W-1:0] tm, logic [DAY_W-1:0] td);
      longint due_val;
      longint diff;
      due_val = due;
      diff = day_index(ty, tm, td)
           - day_index(due_val / 10000, (due_val % 10000) / 100, due_val % 100);
      if (diff > OVERDUE_MAX) begin
         diff = OVERDUE_MAX;
      end else if (diff < OVERDUE_MIN) begin
         diff = OVERDUE_MIN;
      end
      return OUT_W'(diff);
   endfunction

   function automatic logic [DUE_W-1:0] pack_due(int y, int m, int d);
      return DUE_W'(y * 10000 + m * 100 + d);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_overdue.size() == 0) begin
            $error("overdue_days: expected none, actual %0d", rsp_overdue_days);
            mismatch_count++;
         end else begin
            oldest_overdue = pending_overdue.pop_front();
            if (rsp_overdue_days !== oldest_overdue) begin
               $error("overdue_days: expected %0d, actual %0d",
                      oldest_overdue, rsp_overdue_days);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_request(input logic [DUE_W-1:0] due, input logic [YEAR_W-1:0] ty,
         input logic [MON_W-1:0] tm, input logic [DAY_W-1:0] td);
      int unsigned gap_mode;
      gap_mode = idle_enabled ? $urandom_range(0, 5) : 0;
      if (gap_mode >= 3) begin
         start <= 1'b0;
         // sometimes let the block finish before the gap
         if (gap_mode == 5) begin
            do @(posedge clock); while (busy);
         end
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start               <= 1'b1;
      req_due_date_packed <= due;
      req_today_year      <= ty;
      req_today_month     <= tm;
      req_today_day       <= td;
      do @(posedge clock); while (busy);
      pending_overdue.push_back(overdue_for(due, ty, tm, td));
   endtask

   task automatic test_field_extremes;
      send_request('0, '0, '0, '0);
      send_request('1, '1, '1, '1);
      send_request('1, '0, '0, '0);
      send_request('0, '1, '1, '1);
      send_request(pack_due(1900, 1, 1), 2099, 12, 31);
      send_request(pack_due(2099, 12, 31), 1900, 1, 1);
      send_request(pack_due(2024, 3, 15), 2024, 3, 15);
   endtask

   task automatic test_leap_rules;
      send_request(pack_due(2000, 2, 28), 2000, 3, 1);
      send_request(pack_due(1900, 2, 28), 1900, 3, 1);
      send_request(pack_due(2024, 2, 29), 2024, 3, 1);
      send_request(pack_due(2100, 2, 28), 2100, 3, 1);
      send_request(pack_due(1600, 2, 28), 1600, 3, 1);
      send_request(pack_due(0, 2, 29), 0, 3, 1);
      send_request(pack_due(2023, 12, 31), 2024, 1, 1);
      send_request(pack_due(1999, 1, 1), 2001, 1, 1);
   endtask

   // zero month, months past December, zero and oversized days
   task automatic test_malformed_dates;
      send_request(pack_due(2024, 0, 0), 2024, 0, 0);
      send_request(pack_due(2024, 12, 31), 2024, 13, 0);
      send_request(pack_due(2024, 12, 31), 2024, 15, 31);
      send_request(pack_due(2023, 99, 99), 2024, 1, 1);
      send_request(pack_due(2023, 4, 31), 2023, 5, 0);
      send_request(pack_due(2023, 2, 31), 2023, 2, 31);
   endtask

   task automatic test_random_dates(input int count);
      int dy;
      for (int i = 0; i < count; i++) begin
         dy = $urandom_range(1900, 2099);
         send_request(pack_due(dy, $urandom_range(1, 12), $urandom_range(1, 31)),
                      $urandom_range(1900, 2099), $urandom_range(1, 12),
                      $urandom_range(1, 31));
      end
   endtask

   task automatic test_nearby_dates(input int count);
      int dy;
      int ty;
      for (int i = 0; i < count; i++) begin
         dy = $urandom_range(1900, 2099);
         ty = dy + $urandom_range(0, 4) - 2;
         if (ty < 1900) ty = 1900;
         if (ty > 2099) ty = 2099;
         send_request(pack_due(dy, $urandom_range(1, 12), $urandom_range(1, 31)),
                      ty, $urandom_range(1, 12), $urandom_range(1, 31));
      end
   endtask

   task automatic test_full_range_fields(input int count);
      for (int i = 0; i < count; i++) begin
         send_request(DUE_W'($urandom()), YEAR_W'($urandom()), MON_W'($urandom()),
                      DAY_W'($urandom()));
      end
   endtask

   task automatic test_back_to_back(input int count);
      idle_enabled = 1'b0;
      test_nearby_dates(count / 2);
      test_random_dates(count - count / 2);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_leap_rules();
      test_malformed_dates();
      test_random_dates(700);
      test_nearby_dates(350);
      test_full_range_fields(300);
      test_back_to_back(180);
      start <= 1'b0;
      while (pending_overdue.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS days_between_dates_top");
      end else begin
         $display("FAIL days_between_dates_top");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/dbd_pkg.sv
src/dbd_div.sv
src/days_between_dates_top.sv
src/dbd_checker.sv
sim/days_between_dates_top_tb.sv
